FILE: hdl/tof_iq_to_depth_point_macros.svh
// Assertion helpers shared by the depth point pipeline.
`ifndef TOF_IQ_TO_DEPTH_POINT_MACROS_SVH
`define TOF_IQ_TO_DEPTH_POINT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TOFD_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TOFD_ASSERT_NXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tofd_pkg.sv
`default_nettype none

package tofd_pkg;

    localparam int ANGLE_STEPS_DEF = 16;
    localparam int ATAN_TABLE_LEN  = 24;
    localparam int SQRT_STEPS      = 16;
    localparam int CORDIC_W        = 34;
    localparam int PRESCALE_SHIFT  = 14;

    localparam logic [15:0] FULL_TURN_RESET = 16'd29979;
    localparam logic [31:0] ACC_HALF_TURN   = 32'h8000_0000;
    localparam logic [31:0] PHASE_ROUND     = 32'h0000_8000;
    localparam logic [16:0] MAPPED_FULL     = 17'h1_0000;
    localparam logic [32:0] DIST_ROUND      = 33'd32768;
    localparam logic signed [33:0] POINT_ROUND = 34'sd16384;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic [31:0]                acc;
        logic                       zero;
        logic signed [15:0]         dir_x;
        logic signed [15:0]         dir_y;
        logic signed [15:0]         dir_z;
        logic [31:0]                sq_n;
        logic [31:0]                sq_r;
        logic [31:0]                sq_q;
    } iter_data_t;

    // atan(2^-k) with 2^32 per turn
    function automatic logic [31:0] atan_turn(input int k);
        logic [31:0] val;
        unique case (k)
            0:       val = 32'h20000000;
            1:       val = 32'h12E4051E;
            2:       val = 32'h09FB385B;
            3:       val = 32'h051111D4;
            4:       val = 32'h028B0D43;
            5:       val = 32'h0145D7E1;
            6:       val = 32'h00A2F61E;
            7:       val = 32'h00517C55;
            8:       val = 32'h0028BE53;
            9:       val = 32'h00145F2F;
            10:      val = 32'h000A2F98;
            11:      val = 32'h000517CC;
            12:      val = 32'h00028BE6;
            13:      val = 32'h000145F3;
            14:      val = 32'h0000A2FA;
            15:      val = 32'h0000517D;
            16:      val = 32'h000028BE;
            17:      val = 32'h0000145F;
            18:      val = 32'h00000A30;
            19:      val = 32'h00000518;
            20:      val = 32'h0000028C;
            21:      val = 32'h00000146;
            22:      val = 32'h000000A3;
            23:      val = 32'h00000051;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/tofd_iter_stage.sv
`default_nettype none

module tofd_iter_stage
    import tofd_pkg::*;
#(
    parameter int ANGLE_STEPS = ANGLE_STEPS_DEF,
    parameter int STEP        = 0
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       load,
    input  wire logic       in_valid,
    input  wire iter_data_t in_data,
    output logic            out_valid,
    output iter_data_t      out_data
);

    localparam bit DO_CORDIC = (STEP < ANGLE_STEPS) && (STEP < ATAN_TABLE_LEN);
    localparam bit DO_SUM    = (STEP == 0);
    localparam bit DO_SQRT   = (STEP >= 1) && (STEP <= SQRT_STEPS);
    localparam int CSHIFT    = DO_CORDIC ? STEP : 0;
    localparam int SQ_SHIFT  = DO_SQRT ? (30 - 2 * (STEP - 1)) : 0;
    localparam logic [31:0] ATAN   = atan_turn(CSHIFT);
    localparam logic [31:0] SQ_BIT = 32'd1 << SQ_SHIFT;

    logic       valid_reg;
    iter_data_t data_reg;
    iter_data_t data_next;
    logic [31:0] trial;

    always_comb begin
        data_next = in_data;
        trial     = in_data.sq_r + SQ_BIT;
        if (DO_CORDIC) begin
            // zero sign of y rotates as positive
            if (!in_data.y[CORDIC_W-1]) begin
                data_next.x   = in_data.x + (in_data.y >>> CSHIFT);
                data_next.y   = in_data.y - (in_data.x >>> CSHIFT);
                data_next.acc = in_data.acc + ATAN;
            end else begin
                data_next.x   = in_data.x - (in_data.y >>> CSHIFT);
                data_next.y   = in_data.y + (in_data.x >>> CSHIFT);
                data_next.acc = in_data.acc - ATAN;
            end
        end
        if (DO_SUM) begin
            data_next.sq_n = in_data.sq_n + in_data.sq_q;
        end
        if (DO_SQRT) begin
            // one root bit per stage, remainder kept in sq_n
            if (in_data.sq_n >= trial) begin
                data_next.sq_n = in_data.sq_n - trial;
                data_next.sq_r = (in_data.sq_r >> 1) + SQ_BIT;
            end else begin
                data_next.sq_r = in_data.sq_r >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

FILE: hdl/tof_iq_to_depth_point.sv
// Path: input register, iteration stages, then the phase, distance and point stages.
// Throughput: one item per cycle; every stage advances on its own when the next one is free.
// The vectoring loop runs at most one CORDIC step and one square-root bit per iteration stage.
// Reset (aresetn low, synchronous): all stages empty, full_turn_distance back to 29979.
`default_nettype none
`include "tof_iq_to_depth_point_macros.svh"

module tof_iq_to_depth_point
    import tofd_pkg::*;
#(
    parameter int ANGLE_STEPS = ANGLE_STEPS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [15:0]        cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_in_phase,
    input  wire logic signed [15:0] s_quadrature,
    input  wire logic signed [15:0] s_dir_x,
    input  wire logic signed [15:0] s_dir_y,
    input  wire logic signed [15:0] s_dir_z,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [16:0]      m_point_x,
    output logic signed [16:0]      m_point_y,
    output logic signed [16:0]      m_point_z,
    output logic [15:0]             m_distance,
    output logic [15:0]             m_amplitude
);

    localparam int ITER_STAGES = (ANGLE_STEPS > SQRT_STEPS) ? ANGLE_STEPS : (SQRT_STEPS + 1);

    logic [15:0] full_turn_distance_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_turn_distance_reg <= FULL_TURN_RESET;
        end else if (cfg_wr_en) begin
            full_turn_distance_reg <= cfg_wr_data;
        end
    end

    // stage index 0 is the input register, 1..ITER_STAGES the iteration stages
    logic       stage_valid [0:ITER_STAGES];
    iter_data_t stage_data  [0:ITER_STAGES];
    logic       stage_ready [0:ITER_STAGES+1];

    logic ph_ready;
    logic ds_ready;
    logic pt_ready;

    // ---------------- input stage: prescale, fold left half plane, squares
    logic       a_valid_reg;
    iter_data_t a_data_reg;
    iter_data_t a_data_next;
    logic signed [CORDIC_W-1:0] a_x;
    logic signed [CORDIC_W-1:0] a_y;
    logic signed [31:0] a_sq_i;
    logic signed [31:0] a_sq_q;

    always_comb begin
        a_x    = CORDIC_W'(s_in_phase) <<< PRESCALE_SHIFT;
        a_y    = CORDIC_W'(s_quadrature) <<< PRESCALE_SHIFT;
        a_sq_i = 32'(s_in_phase) * 32'(s_in_phase);
        a_sq_q = 32'(s_quadrature) * 32'(s_quadrature);
        a_data_next.zero  = (s_in_phase == 16'sd0) && (s_quadrature == 16'sd0);
        a_data_next.dir_x = s_dir_x;
        a_data_next.dir_y = s_dir_y;
        a_data_next.dir_z = s_dir_z;
        a_data_next.sq_n  = a_sq_i;
        a_data_next.sq_q  = a_sq_q;
        a_data_next.sq_r  = 32'd0;
        if (s_in_phase[15]) begin
            a_data_next.x   = -a_x;
            a_data_next.y   = -a_y;
            a_data_next.acc = ACC_HALF_TURN;
        end else begin
            a_data_next.x   = a_x;
            a_data_next.y   = a_y;
            a_data_next.acc = 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (stage_ready[0]) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[0]) begin
            a_data_reg <= a_data_next;
        end
    end

    assign stage_valid[0] = a_valid_reg;
    assign stage_data[0]  = a_data_reg;
    assign s_ready        = stage_ready[0];

    // ---------------- iteration stages
    for (genvar k = 0; k <= ITER_STAGES; k++) begin : g_ready
        assign stage_ready[k] = !stage_valid[k] || stage_ready[k+1];
    end
    assign stage_ready[ITER_STAGES+1] = ph_ready;

    for (genvar k = 0; k < ITER_STAGES; k++) begin : g_iter
        tofd_iter_stage #(
            .ANGLE_STEPS (ANGLE_STEPS),
            .STEP        (k)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .load      (stage_ready[k+1]),
            .in_valid  (stage_valid[k]),
            .in_data   (stage_data[k]),
            .out_valid (stage_valid[k+1]),
            .out_data  (stage_data[k+1])
        );
    end

    // ---------------- phase stage: round angle, map, round root
    iter_data_t         ph_in;
    logic               ph_valid_reg;
    logic [16:0]        ph_mapped_reg;
    logic [15:0]        ph_amp_reg;
    logic signed [15:0] ph_dir_x_reg;
    logic signed [15:0] ph_dir_y_reg;
    logic signed [15:0] ph_dir_z_reg;
    logic [31:0]        ph_acc_rnd;
    logic [15:0]        ph_phase;

    assign ph_in = stage_data[ITER_STAGES];

    always_comb begin
        ph_acc_rnd = ph_in.acc + PHASE_ROUND;
        ph_phase   = ph_in.zero ? 16'd0 : ph_acc_rnd[31:16];
    end

    assign ph_ready = !ph_valid_reg || ds_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_valid_reg <= 1'b0;
        end else if (ph_ready) begin
            ph_valid_reg <= stage_valid[ITER_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (ph_ready) begin
            ph_mapped_reg <= MAPPED_FULL - {1'b0, ph_phase};
            ph_amp_reg    <= ph_in.sq_r[15:0] + {15'd0, (ph_in.sq_n > ph_in.sq_r)};
            ph_dir_x_reg  <= ph_in.dir_x;
            ph_dir_y_reg  <= ph_in.dir_y;
            ph_dir_z_reg  <= ph_in.dir_z;
        end
    end

    // ---------------- distance stage
    logic               ds_valid_reg;
    logic [15:0]        ds_dist_reg;
    logic [15:0]        ds_amp_reg;
    logic signed [15:0] ds_dir_x_reg;
    logic signed [15:0] ds_dir_y_reg;
    logic signed [15:0] ds_dir_z_reg;
    logic [32:0]        ds_prod;

    assign ds_prod  = 33'(ph_mapped_reg) * 33'(full_turn_distance_reg) + DIST_ROUND;
    assign ds_ready = !ds_valid_reg || pt_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ds_valid_reg <= 1'b0;
        end else if (ds_ready) begin
            ds_valid_reg <= ph_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ds_ready) begin
            ds_dist_reg  <= ds_prod[31:16];
            ds_amp_reg   <= ph_amp_reg;
            ds_dir_x_reg <= ph_dir_x_reg;
            ds_dir_y_reg <= ph_dir_y_reg;
            ds_dir_z_reg <= ph_dir_z_reg;
        end
    end

    // ---------------- point stage, doubles as the output register
    logic                pt_valid_reg;
    logic signed [16:0]  pt_x_reg;
    logic signed [16:0]  pt_y_reg;
    logic signed [16:0]  pt_z_reg;
    logic [15:0]         pt_dist_reg;
    logic [15:0]         pt_amp_reg;
    logic signed [16:0]  pt_dist_s;
    logic signed [33:0]  pt_px;
    logic signed [33:0]  pt_py;
    logic signed [33:0]  pt_pz;

    always_comb begin
        pt_dist_s = signed'({1'b0, ds_dist_reg});
        pt_px = 34'(ds_dir_x_reg) * 34'(pt_dist_s) + POINT_ROUND;
        pt_py = 34'(ds_dir_y_reg) * 34'(pt_dist_s) + POINT_ROUND;
        pt_pz = 34'(ds_dir_z_reg) * 34'(pt_dist_s) + POINT_ROUND;
    end

    assign pt_ready = !pt_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pt_valid_reg <= 1'b0;
        end else if (pt_ready) begin
            pt_valid_reg <= ds_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pt_ready) begin
            pt_x_reg    <= pt_px[31:15];
            pt_y_reg    <= pt_py[31:15];
            pt_z_reg    <= pt_pz[31:15];
            pt_dist_reg <= ds_dist_reg;
            pt_amp_reg  <= ds_amp_reg;
        end
    end

    assign m_valid     = pt_valid_reg;
    assign m_point_x   = pt_x_reg;
    assign m_point_y   = pt_y_reg;
    assign m_point_z   = pt_z_reg;
    assign m_distance  = pt_dist_reg;
    assign m_amplitude = pt_amp_reg;

    // ---------------- assertions
    `TOFD_ASSERT_IMP(a_mapped_nonzero, aclk, aresetn, ph_valid_reg, ph_mapped_reg != 17'd0, "mapped phase is zero")
    `TOFD_ASSERT_IMP(a_amp_range, aclk, aresetn, m_valid, m_amplitude <= 16'd46341, "amplitude out of range")
    `TOFD_ASSERT_IMP(a_stall_full, aclk, aresetn, !s_ready, a_valid_reg, "input stalled while input stage empty")
    `TOFD_ASSERT_NXT(a_input_hold, aclk, aresetn, a_valid_reg && !stage_ready[1], a_valid_reg, "input stage dropped an item")

endmodule

`default_nettype wire
